@@ design/ccs_pkg.sv @@
// shared types, constants and calendar helpers for the calendar clock
package ccs_pkg;

    // knob sample resolution
    localparam int KNOB_BITS = 10;

    // field widths
    localparam int KIND_W   = 2;
    localparam int ADC_W    = 10;
    localparam int YEAR_W   = 12;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;
    localparam int HUND_W   = 7;
    localparam int PHASE_W  = 3;

    // widest knob span (the year field, 200 values)
    localparam int SPAN_W = 8;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_TICK    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SAMPLE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CONFIRM = 2'd2;
    localparam logic [KIND_W-1:0] KIND_START   = 2'd3;

    // phase codes
    localparam logic [PHASE_W-1:0] PH_YEAR   = 3'd0;
    localparam logic [PHASE_W-1:0] PH_MONTH  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_DAY    = 3'd2;
    localparam logic [PHASE_W-1:0] PH_HOUR   = 3'd3;
    localparam logic [PHASE_W-1:0] PH_MINUTE = 3'd4;
    localparam logic [PHASE_W-1:0] PH_SECOND = 3'd5;
    localparam logic [PHASE_W-1:0] PH_READY  = 3'd6;
    localparam logic [PHASE_W-1:0] PH_RUN    = 3'd7;

    // calendar limits and reset values
    localparam logic [YEAR_W-1:0]  YEAR_LO    = 12'd1900;
    localparam logic [YEAR_W-1:0]  YEAR_HI    = 12'd2099;
    localparam logic [YEAR_W-1:0]  YEAR_RESET = 12'd2026;
    localparam logic [MONTH_W-1:0] MONTH_HI   = 4'd12;
    localparam logic [HUND_W-1:0]  HUND_MOD   = 7'd100;
    localparam logic [SECOND_W-1:0] SEC_MOD   = 6'd60;
    localparam logic [MINUTE_W-1:0] MIN_MOD   = 6'd60;
    localparam logic [HOUR_W-1:0]  HOUR_MOD   = 5'd24;

    // input item
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ADC_W-1:0]  adc_value;
    } in_item_t;

    // result item, also the shape of the clock state
    typedef struct packed {
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
        logic [HUND_W-1:0]   hundredths;
        logic [PHASE_W-1:0]  phase;
    } out_item_t;

    // leap rule; the year always stays in 1900..2099, where 1900 is the
    // only century year that is not a leap year
    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        return (y[1:0] == 2'b00) && (y != YEAR_LO);
    endfunction

    // days in a month, 31 for a month code out of range
    function automatic logic [DAY_W-1:0] month_days(input logic [YEAR_W-1:0] y,
                                                    input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        unique case (m) inside
            4'd2:                     len = is_leap(y) ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            default:                  len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

@@ design/ccs_knob.sv @@
// knob mapper: lo + adc*span >> KNOB_BITS, clamped to hi
module ccs_knob (
    input  logic [ccs_pkg::KNOB_BITS-1:0] adc,
    input  logic [ccs_pkg::YEAR_W-1:0]    lo,
    input  logic [ccs_pkg::YEAR_W-1:0]    hi,
    output logic [ccs_pkg::YEAR_W-1:0]    value
);

    localparam int PROD_W = ccs_pkg::KNOB_BITS + ccs_pkg::SPAN_W;

    logic [ccs_pkg::SPAN_W-1:0] span;
    logic [PROD_W-1:0]          prod;
    logic [ccs_pkg::SPAN_W-1:0] scaled;
    logic [ccs_pkg::YEAR_W-1:0] sum;

    // span of the field and the scaled sample
    assign span   = ccs_pkg::SPAN_W'(hi - lo + 12'd1);
    assign prod   = PROD_W'(adc) * PROD_W'(span);
    assign scaled = prod[PROD_W-1:ccs_pkg::KNOB_BITS];

    // offset and clamp
    assign sum   = lo + ccs_pkg::YEAR_W'(scaled);
    assign value = (sum > hi) ? hi : sum;

endmodule

@@ design/ccs_step.sv @@
// next clock state for one item: tick cascade, knob setting, phase steps
module ccs_step (
    input  ccs_pkg::in_item_t  item,
    input  ccs_pkg::out_item_t cur,
    output ccs_pkg::out_item_t nxt
);

    logic [ccs_pkg::KNOB_BITS-1:0] knob;
    logic [ccs_pkg::YEAR_W-1:0]    knob_lo;
    logic [ccs_pkg::YEAR_W-1:0]    knob_hi;
    logic [ccs_pkg::YEAR_W-1:0]    knob_val;
    logic [ccs_pkg::DAY_W-1:0]     cur_len;

    logic [ccs_pkg::HUND_W-1:0]   hund_inc;
    logic [ccs_pkg::SECOND_W-1:0] sec_inc;
    logic [ccs_pkg::MINUTE_W-1:0] min_inc;
    logic [ccs_pkg::HOUR_W-1:0]   hour_inc;
    logic [ccs_pkg::DAY_W:0]      day_inc;
    logic [ccs_pkg::MONTH_W-1:0]  month_inc;
    logic [ccs_pkg::YEAR_W-1:0]   year_inc;

    // only the low knob bits of the sample count
    assign knob    = ccs_pkg::KNOB_BITS'(item.adc_value);
    assign cur_len = ccs_pkg::month_days(cur.year, cur.month);

    // field range for the phase being set
    always_comb
    begin
        unique case (cur.phase)
            ccs_pkg::PH_YEAR:
            begin
                knob_lo = ccs_pkg::YEAR_LO;
                knob_hi = ccs_pkg::YEAR_HI;
            end
            ccs_pkg::PH_MONTH:
            begin
                knob_lo = 12'd1;
                knob_hi = ccs_pkg::YEAR_W'(ccs_pkg::MONTH_HI);
            end
            ccs_pkg::PH_DAY:
            begin
                knob_lo = 12'd1;
                knob_hi = ccs_pkg::YEAR_W'(cur_len);
            end
            ccs_pkg::PH_HOUR:
            begin
                knob_lo = 12'd0;
                knob_hi = 12'd23;
            end
            default:
            begin
                knob_lo = 12'd0;
                knob_hi = 12'd59;
            end
        endcase
    end

    ccs_knob u_knob (
        .adc   (knob),
        .lo    (knob_lo),
        .hi    (knob_hi),
        .value (knob_val)
    );

    // incremented fields for the cascade
    assign hund_inc  = cur.hundredths + 7'd1;
    assign sec_inc   = cur.second + 6'd1;
    assign min_inc   = cur.minute + 6'd1;
    assign hour_inc  = cur.hour + 5'd1;
    assign day_inc   = {1'b0, cur.day} + 6'd1;
    assign month_inc = cur.month + 4'd1;
    assign year_inc  = cur.year + 12'd1;

    // state update by item kind
    always_comb
    begin
        nxt = cur;
        unique case (item.kind)
            ccs_pkg::KIND_TICK:
            begin
                if (cur.phase == ccs_pkg::PH_RUN)
                begin
                    if (hund_inc < ccs_pkg::HUND_MOD)
                        nxt.hundredths = hund_inc;
                    else
                    begin
                        nxt.hundredths = '0;
                        if (sec_inc < ccs_pkg::SEC_MOD)
                            nxt.second = sec_inc;
                        else
                        begin
                            nxt.second = '0;
                            if (min_inc < ccs_pkg::MIN_MOD)
                                nxt.minute = min_inc;
                            else
                            begin
                                nxt.minute = '0;
                                if (hour_inc < ccs_pkg::HOUR_MOD)
                                    nxt.hour = hour_inc;
                                else
                                begin
                                    nxt.hour = '0;
                                    if (day_inc <= {1'b0, cur_len})
                                        nxt.day = day_inc[ccs_pkg::DAY_W-1:0];
                                    else
                                    begin
                                        nxt.day = 5'd1;
                                        if (month_inc <= ccs_pkg::MONTH_HI)
                                            nxt.month = month_inc;
                                        else
                                        begin
                                            nxt.month = 4'd1;
                                            nxt.year  = (year_inc > ccs_pkg::YEAR_HI)
                                                        ? ccs_pkg::YEAR_LO : year_inc;
                                        end
                                    end
                                end
                            end
                        end
                    end
                end
            end
            ccs_pkg::KIND_SAMPLE:
            begin
                case (cur.phase)
                    ccs_pkg::PH_YEAR:   nxt.year   = knob_val;
                    ccs_pkg::PH_MONTH:  nxt.month  = ccs_pkg::MONTH_W'(knob_val);
                    ccs_pkg::PH_DAY:    nxt.day    = ccs_pkg::DAY_W'(knob_val);
                    ccs_pkg::PH_HOUR:   nxt.hour   = ccs_pkg::HOUR_W'(knob_val);
                    ccs_pkg::PH_MINUTE: nxt.minute = ccs_pkg::MINUTE_W'(knob_val);
                    ccs_pkg::PH_SECOND: nxt.second = ccs_pkg::SECOND_W'(knob_val);
                    default:            ;
                endcase
            end
            ccs_pkg::KIND_CONFIRM:
            begin
                if (cur.phase < ccs_pkg::PH_SECOND)
                    nxt.phase = cur.phase + 3'd1;
                else if (cur.phase == ccs_pkg::PH_SECOND)
                begin
                    nxt.hundredths = '0;
                    nxt.phase      = ccs_pkg::PH_READY;
                end
            end
            default:
            begin
                if (cur.phase == ccs_pkg::PH_READY)
                begin
                    nxt.hundredths = '0;
                    nxt.phase      = ccs_pkg::PH_RUN;
                end
            end
        endcase
    end

endmodule

@@ design/calendar_clock_with_setting_core.sv @@
// calendar clock core: input register, state update and result register
// an accepted item waits in the input register until the result register is free
// or emptying, and then its updated state is registered in the result register
// throughput: one item per cycle while the result register is not stalled
// reset: rst_n clears both stages and loads 2026-01-01 00:00:00.00, setting year
module calendar_clock_with_setting_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  ccs_pkg::in_item_t  item,
    output logic               result_valid,
    input  logic               result_ready,
    output ccs_pkg::out_item_t result
);

    logic               in_valid_reg;
    ccs_pkg::in_item_t  in_item_reg;
    ccs_pkg::out_item_t state_reg;
    ccs_pkg::out_item_t state_next;
    logic               out_valid_reg;
    ccs_pkg::out_item_t out_item_reg;
    logic               advance;

    // the held item moves on when the result register is free or emptying
    assign advance    = in_valid_reg && (!out_valid_reg || result_ready);
    assign item_ready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (item_ready)
            in_valid_reg <= item_valid;
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
            in_item_reg <= item;
    end

    ccs_step u_step (
        .item (in_item_reg),
        .cur  (state_reg),
        .nxt  (state_next)
    );

    // clock state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.year       <= ccs_pkg::YEAR_RESET;
            state_reg.month      <= 4'd1;
            state_reg.day        <= 5'd1;
            state_reg.hour       <= '0;
            state_reg.minute     <= '0;
            state_reg.second     <= '0;
            state_reg.hundredths <= '0;
            state_reg.phase      <= ccs_pkg::PH_YEAR;
        end
        else if (advance)
            state_reg <= state_next;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (result_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_item_reg <= state_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;

    // the phase only ever moves forward
    a_phase_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> state_reg.phase >= $past(state_reg.phase))
        else $error("phase moved backward");

    // state changes only when an item is processed
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("state changed without an item");

    // a fresh result shows the updated state
    a_result_state: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (out_item_reg == state_reg) && out_valid_reg)
        else $error("result differs from state");

    // hundredths stay below one hundred
    a_hund_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.hundredths < ccs_pkg::HUND_MOD)
        else $error("hundredths out of range");

    // input stalls only behind a full, stalled result register
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> in_valid_reg && out_valid_reg && !result_ready)
        else $error("input stalled without cause");

endmodule
